### hw/rtl/fpa_pkg.sv
// Shared types, opcodes and size constants for the fixed-point ALU.
// No dependencies; used by every module under hw/rtl.
package fpa_pkg;

   localparam int MAX_WORD_BITS = 32;
   localparam int MAX_FRAC_BITS = 16;
   localparam int NUM_BITS      = MAX_WORD_BITS + MAX_FRAC_BITS + 1;
   localparam int REM_BITS      = MAX_WORD_BITS + 1;
   localparam int DEF_WORD_BITS = 32;
   localparam int DEF_FRAC_BITS = 8;

   localparam logic [3:0] OP_ADD     = 4'd0;
   localparam logic [3:0] OP_SUB     = 4'd1;
   localparam logic [3:0] OP_MUL     = 4'd2;
   localparam logic [3:0] OP_DIV     = 4'd3;
   localparam logic [3:0] OP_GT      = 4'd4;
   localparam logic [3:0] OP_LT      = 4'd5;
   localparam logic [3:0] OP_GE      = 4'd6;
   localparam logic [3:0] OP_LE      = 4'd7;
   localparam logic [3:0] OP_EQ      = 4'd8;
   localparam logic [3:0] OP_NE      = 4'd9;
   localparam logic [3:0] OP_MIN     = 4'd10;
   localparam logic [3:0] OP_MAX     = 4'd11;
   localparam logic [3:0] OP_INC     = 4'd12;
   localparam logic [3:0] OP_DEC     = 4'd13;
   localparam logic [3:0] OP_TOINT   = 4'd14;
   localparam logic [3:0] OP_FROMINT = 4'd15;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               overflowed;
      logic               divide_by_zero;
   } rsp_type;

   // data carried along the cell chain
   typedef struct packed {
      logic [3:0]               opcode;
      logic signed [31:0]       res;
      logic                     cmp;
      logic                     ovf;
      logic                     dz;
      logic signed [63:0]       prod;
      logic                     neg;
      logic [REM_BITS-1:0]      rem;
      logic [MAX_WORD_BITS-1:0] den;
      logic [NUM_BITS-1:0]      num;
   } lane_type;

endpackage

### hw/rtl/fixed_point_q24_8_alu.sv
// Q24.8 fixed-point ALU: entry stage, chain of division cells, exit stage.
// Throughput: one transfer per cycle while rsp_stall is low; each division cell settles one quotient bit.
// Every stage holds its item while the next one is full and stalled, so bubbles collapse.
// Synchronous reset clears all stage valid flags; payload registers are not reset.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_back.
module fixed_point_q24_8_alu #(
   parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fpa_pkg::rsp_type rsp_data
);
   localparam int NCELL = WORD_BITS + FRAC_BITS + 1;
   localparam logic signed [31:0] RMAX = 32'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
   localparam logic signed [31:0] RMIN = -RMAX - 32'sd1;

   fpa_pkg::lane_type lane [NCELL+1];
   logic [NCELL:0]    vld, rdy;
   logic              front_ready;

   assign req_stall = !front_ready;

   fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(front_ready), .in_data(req_data),
      .out_valid(vld[0]), .out_ready(rdy[0]), .out_data(lane[0])
   );

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      fpa_div_cell #(.NUM_MSB(NCELL - 1)) u_cell (
         .clock(clock), .reset(reset),
         .in_valid(vld[i]), .in_ready(rdy[i]), .in_data(lane[i]),
         .out_valid(vld[i+1]), .out_ready(rdy[i+1]), .out_data(lane[i+1])
      );
   end

   fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(vld[NCELL]), .in_ready(rdy[NCELL]), .in_data(lane[NCELL]),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp_data)
   );

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> !rsp_data.overflowed)
      else $error("divide by zero flagged with overflow");

   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_true |-> rsp_data.result_value == 32'sd0)
      else $error("compare result carries a nonzero value");

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflowed |->
         rsp_data.result_value == RMAX || rsp_data.result_value == RMIN)
      else $error("saturated result is not a bound");

   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_true |->
         !rsp_data.overflowed && !rsp_data.divide_by_zero)
      else $error("compare result carries error flags");
endmodule

### hw/rtl/fpa_front.sv
// Entry stage: operand sign extension, simple operations, multiplier, divider setup.
// Depends on fpa_pkg.
module fpa_front #(
   parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpa_pkg::lane_type out_data
);
   localparam int SH = fpa_pkg::MAX_WORD_BITS - WORD_BITS;
   localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

   logic                 valid_ff;
   fpa_pkg::lane_type    lane_ff, lane_in;
   logic signed [31:0]   a_sh, b_sh, a_w, b_w;
   logic signed [63:0]   a64, b64, raw;
   logic [31:0]          mag_a, mag_b;
   logic                 clampit;

   assign a_sh = in_data.operand_a <<< SH;
   assign b_sh = in_data.operand_b <<< SH;
   assign a_w  = a_sh >>> SH;
   assign b_w  = b_sh >>> SH;
   assign a64  = {{32{a_w[31]}}, a_w};
   assign b64  = {{32{b_w[31]}}, b_w};
   assign mag_a = a_w[31] ? 32'(-a_w) : 32'(a_w);
   assign mag_b = b_w[31] ? 32'(-b_w) : 32'(b_w);

   always_comb begin
      raw     = 64'sd0;
      clampit = 1'b0;
      lane_in = '0;
      lane_in.opcode = in_data.opcode;
      lane_in.prod   = a_w * b_w;
      lane_in.neg    = a_w[31] ^ b_w[31];
      lane_in.den    = mag_b;
      lane_in.num    = {{(fpa_pkg::NUM_BITS - 32){1'b0}}, mag_a} << (FRAC_BITS + 1);
      case (in_data.opcode)
         fpa_pkg::OP_ADD: begin
            raw = a64 + b64; clampit = 1'b1;
         end
         fpa_pkg::OP_SUB: begin
            raw = a64 - b64; clampit = 1'b1;
         end
         fpa_pkg::OP_DIV: begin
            if (b_w == 32'sd0) begin
               lane_in.dz = 1'b1;
               raw = (a64 > 0) ? WMAX : ((a64 < 0) ? WMIN : 64'sd0);
            end
         end
         fpa_pkg::OP_GT: lane_in.cmp = a_w > b_w;
         fpa_pkg::OP_LT: lane_in.cmp = a_w < b_w;
         fpa_pkg::OP_GE: lane_in.cmp = a_w >= b_w;
         fpa_pkg::OP_LE: lane_in.cmp = a_w <= b_w;
         fpa_pkg::OP_EQ: lane_in.cmp = a_w == b_w;
         fpa_pkg::OP_NE: lane_in.cmp = a_w != b_w;
         fpa_pkg::OP_MIN: raw = (a64 < b64) ? a64 : b64;
         fpa_pkg::OP_MAX: raw = (a64 > b64) ? a64 : b64;
         fpa_pkg::OP_INC: begin
            raw = a64 + 64'sd1; clampit = 1'b1;
         end
         fpa_pkg::OP_DEC: begin
            raw = a64 - 64'sd1; clampit = 1'b1;
         end
         fpa_pkg::OP_TOINT: raw = a64 >>> FRAC_BITS;
         fpa_pkg::OP_FROMINT: begin
            raw = a64 <<< FRAC_BITS; clampit = 1'b1;
         end
         default: raw = 64'sd0;
      endcase
      if (clampit && raw > WMAX) begin
         raw = WMAX; lane_in.ovf = 1'b1;
      end else if (clampit && raw < WMIN) begin
         raw = WMIN; lane_in.ovf = 1'b1;
      end
      lane_in.res = raw[31:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         lane_ff <= lane_in;
      end
   end
endmodule

### hw/rtl/fpa_div_cell.sv
// One restoring-division cell: one quotient bit per transfer through the chain.
// Depends on fpa_pkg.
module fpa_div_cell #(
   parameter int NUM_MSB = fpa_pkg::NUM_BITS - 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::lane_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpa_pkg::lane_type out_data
);
   logic                            valid_ff;
   fpa_pkg::lane_type               lane_ff, lane_in;
   logic [fpa_pkg::REM_BITS-1:0]    rem_sh;
   logic                            ge;

   assign rem_sh = {in_data.rem[fpa_pkg::REM_BITS-2:0], in_data.num[NUM_MSB]};
   assign ge     = rem_sh >= {1'b0, in_data.den};

   always_comb begin
      lane_in     = in_data;
      lane_in.rem = ge ? rem_sh - {1'b0, in_data.den} : rem_sh;
      lane_in.num = {in_data.num[fpa_pkg::NUM_BITS-2:0], ge};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         lane_ff <= lane_in;
      end
   end
endmodule

### hw/rtl/fpa_back.sv
// Exit stage: multiply and divide rounding, saturation, result register.
// Depends on fpa_pkg.
module fpa_back #(
   parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
   parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::lane_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output fpa_pkg::rsp_type  out_data
);
   localparam int NB = WORD_BITS + FRAC_BITS + 1;
   localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

   logic               valid_ff;
   fpa_pkg::rsp_type   rsp_ff, rsp_in;
   logic [63:0]        pmag, mq, q2, dq;
   logic signed [63:0] val;
   logic               arith;

   assign pmag = in_data.prod[63] ? 64'(-in_data.prod) : 64'(in_data.prod);
   assign mq   = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign q2   = 64'(in_data.num[NB-1:0]);
   assign dq   = (q2 + 64'd1) >> 1;

   always_comb begin
      arith = 1'b0;
      val   = 64'sd0;
      if (in_data.opcode == fpa_pkg::OP_MUL) begin
         arith = 1'b1;
         val   = in_data.prod[63] ? -$signed(mq) : $signed(mq);
      end else if (in_data.opcode == fpa_pkg::OP_DIV && !in_data.dz) begin
         arith = 1'b1;
         val   = in_data.neg ? -$signed(dq) : $signed(dq);
      end
      rsp_in.compare_true   = in_data.cmp;
      rsp_in.divide_by_zero = in_data.dz;
      rsp_in.overflowed     = in_data.ovf;
      rsp_in.result_value   = in_data.res;
      if (arith) begin
         if (val > WMAX) begin
            rsp_in.result_value = WMAX[31:0];
            rsp_in.overflowed   = 1'b1;
         end else if (val < WMIN) begin
            rsp_in.result_value = WMIN[31:0];
            rsp_in.overflowed   = 1'b1;
         end else begin
            rsp_in.result_value = val[31:0];
         end
      end
   end

   assign in_ready  = !valid_ff || !out_stall;
   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         rsp_ff <= rsp_in;
      end
   end
endmodule
